// ===== rtl/multi_rotary_encoder_decoder_unit_assert.svh =====
// Assertion macros used by the merge stage of the encoder decoder RTL.
// No dependencies.
`ifndef MULTI_ROTARY_ENCODER_DECODER_UNIT_ASSERT_SVH
`define MULTI_ROTARY_ENCODER_DECODER_UNIT_ASSERT_SVH
// implication checked every clock outside reset
`define MRE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define MRE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ===== rtl/mred_pkg.sv =====
// Shared types and codes for the rotary encoder decoder.
// No dependencies.
package mred_pkg;
	localparam int MAX_ENC = 8;
	localparam int MAX_REC = 4 * MAX_ENC;

	localparam logic [2:0] ACT_TICK = 3'd0;
	localparam logic [2:0] ACT_SETPOS = 3'd1;
	localparam logic [2:0] ACT_SETDLT = 3'd2;
	localparam logic [2:0] ACT_READ = 3'd3;
	localparam logic [2:0] ACT_ACK = 3'd4;

	localparam logic [2:0] KIND_VALUE = 3'd0;
	localparam logic [2:0] KIND_DELTA = 3'd1;
	localparam logic [2:0] KIND_SWITCH = 3'd2;
	localparam logic [2:0] KIND_POS = 3'd3;
	localparam logic [2:0] KIND_DREAD = 3'd4;
	localparam logic [2:0] KIND_STATUS = 3'd5;
	localparam logic [2:0] KIND_INVALID = 3'd6;

	localparam logic [1:0] SEL_POS = 2'd0;
	localparam logic [1:0] SEL_DLT = 2'd1;
	localparam logic [1:0] SEL_STAT = 2'd2;

	localparam logic [1:0] EDGE_PLVL = 2'd0;
	localparam logic [1:0] EDGE_RLVL = 2'd1;
	localparam logic [1:0] EDGE_PRESS = 2'd2;
	localparam logic [1:0] EDGE_REL = 2'd3;

	// one result record
	typedef struct packed {
		logic [2:0]  kind;
		logic [2:0]  enc;
		logic [31:0] value;
		logic [1:0]  edge_res;
	} rec_t;

	// what one lane reports for a tick
	typedef struct packed {
		logic        step;      // a step counted
		logic        stp_neg;   // step is backward
		logic        sw_plvl;
		logic        sw_rlvl;
		logic        sw_press;
		logic        sw_rel;
		logic [31:0] pos_new;
	} lane_res_t;
endpackage

// ===== rtl/multi_rotary_encoder_decoder_unit.sv =====
// Top level of the multi-lane rotary encoder decoder.
// Depends on mred_pkg, mred_lane and mred_merge.
// Every encoder has its own lane that decodes a tick in the beat's cycle; a
// merge stage holds the records of that beat and sends one record per cycle
// while the receiver is ready, in lane order (value, delta, level, edge
// within a lane). A beat that yields no record leaves the merge stage idle;
// otherwise the next beat is taken while the last record of the previous one
// is being sent. The output drain is what sets the rate: a tick with all
// events enabled yields up to 32 records with eight encoders.
module multi_rotary_encoder_decoder_unit #(
	parameter int NUM_ENCODERS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [47:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	// action[2:0], a_levels[10:3], b_levels[18:11], switch_levels[26:19],
	// encoder_index[30:27], register_select[32:31], write_value[64:33]
	input  logic [71:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// kind[2:0], encoder_id[5:3], value[37:6], edge_res[39:38], irq[40]
	output logic [47:0] m_tdata,
	output logic        m_tlast
);
	import mred_pkg::*;
	localparam int NE = NUM_ENCODERS;
	localparam int NR = 4 * NE;

	logic [47:0] ev_en_q;
	logic [7:0]  irq_en_q;
	logic [NE-1:0] rdy_q, rdy_nxt;

	logic [2:0] act;
	logic [7:0] a_l, b_l, s_l;
	logic [3:0] eidx;
	logic [1:0] rsel;
	logic [31:0] wv;
	assign act = s_tdata[2:0];
	assign a_l = s_tdata[10:3];
	assign b_l = s_tdata[18:11];
	assign s_l = s_tdata[26:19];
	assign eidx = s_tdata[30:27];
	assign rsel = s_tdata[32:31];
	assign wv = s_tdata[64:33];

	logic busy, acc, tick, idx_ok;
	logic out_busy_last;
	rec_t out_rec;
	logic out_last, out_irq, out_valid;

	// accept when queue empty or its last record leaves this cycle
	assign s_tready = !busy || (m_tready && out_last);
	assign acc = s_tvalid && s_tready;
	assign tick = acc && (act == ACT_TICK);
	assign idx_ok = ({1'b0, eidx} < 5'(NE));
	assign out_busy_last = out_last;

	lane_res_t   lres [NE];
	logic [31:0] lpos [NE];
	logic [31:0] ldlt [NE];
	rec_t        recs [NR];
	logic [NR-1:0] vld;

	for (genvar e = 0; e < NE; e++) begin : g_lane
		mred_lane u_lane (
			.clk(clk), .arst_n(arst_n), .tick(tick),
			.set_pos(acc && act == ACT_SETPOS && idx_ok && eidx[2:0] == 3'(e)),
			.set_dlt(acc && act == ACT_SETDLT && idx_ok && eidx[2:0] == 3'(e)),
			.wval(wv),
			.cur({~s_l[e], ~b_l[e], ~a_l[e]}),
			.en(ev_en_q[6*e +: 6]),
			.res(lres[e]), .pos(lpos[e]), .dlt(ldlt[e])
		);
	end

	logic [2:0]  ridx;
	logic [31:0] rdval;
	rec_t        rd_rec;
	assign ridx = eidx[2:0];

	always_comb begin
		rd_rec.enc = ridx;
		rd_rec.edge_res = EDGE_PLVL;
		rd_rec.kind = KIND_INVALID;
		rd_rec.value = '0;
		rdval = '0;
		if (idx_ok) begin
			unique case (rsel)
				SEL_POS: begin
					rd_rec.kind = KIND_POS;
					rdval = lpos[ridx];
				end
				SEL_DLT: begin
					rd_rec.kind = KIND_DREAD;
					rdval = ldlt[ridx];
				end
				SEL_STAT: begin
					rd_rec.kind = KIND_STATUS;
					rdval = {18'd0, ev_en_q[6*ridx +: 6], 7'd0, rdy_q[ridx]};
				end
				default: rd_rec.kind = KIND_INVALID;
			endcase
			rd_rec.value = rdval;
		end
	end

	always_comb begin
		vld = '0;
		rdy_nxt = rdy_q;
		for (int e = 0; e < NE; e++) begin
			recs[4*e] = '{KIND_VALUE, 3'(e), lres[e].pos_new, EDGE_PLVL};
			recs[4*e+1] = '{KIND_DELTA, 3'(e),
				lres[e].stp_neg ? 32'hFFFF_FFFF : 32'd1, EDGE_PLVL};
			recs[4*e+2] = '{KIND_SWITCH, 3'(e), 32'd0,
				lres[e].sw_plvl ? EDGE_PLVL : EDGE_RLVL};
			recs[4*e+3] = '{KIND_SWITCH, 3'(e), 32'd0,
				lres[e].sw_press ? EDGE_PRESS : EDGE_REL};
		end
		if (act == ACT_TICK) begin
			for (int e = 0; e < NE; e++) begin
				vld[4*e] = lres[e].step && ev_en_q[6*e];
				vld[4*e+1] = lres[e].step && ev_en_q[6*e+1];
				vld[4*e+2] = lres[e].sw_plvl || lres[e].sw_rlvl;
				vld[4*e+3] = lres[e].sw_press || lres[e].sw_rel;
				if (lres[e].step || vld[4*e+2] || vld[4*e+3]) rdy_nxt[e] = 1'b1;
			end
		end else if (act == ACT_READ) begin
			recs[0] = rd_rec;
			vld[0] = 1'b1;
		end else if (act == ACT_ACK) begin
			rdy_nxt = '0;
		end
	end

	mred_merge #(.NUM_ENCODERS(NE)) u_merge (
		.clk(clk), .arst_n(arst_n), .load(acc), .recs(recs), .vld(vld),
		.irq_in(|(rdy_nxt & irq_en_q[NE-1:0])), .busy(busy),
		.out_rec(out_rec), .out_last(out_last), .out_irq(out_irq),
		.out_valid(out_valid), .out_ready(m_tready)
	);

	assign m_tvalid = out_valid;
	assign m_tlast = out_busy_last;
	assign m_tdata = {7'd0, out_irq, out_rec.edge_res, out_rec.value,
		out_rec.enc, out_rec.kind};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_en_q <= '0;
			irq_en_q <= '0;
			rdy_q <= '0;
		end else begin
			if (cfg_we) begin
				if (!cfg_index) ev_en_q <= cfg_wdata;
				else irq_en_q <= cfg_wdata[7:0];
			end
			if (acc) rdy_q <= rdy_nxt;
		end
	end
endmodule

// ===== rtl/mred_lane.sv =====
// One encoder lane: edge flags, step detection, position and delta.
// Depends on mred_pkg.
module mred_lane (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   tick,     // tick beat accepted
	input  logic                   set_pos,
	input  logic                   set_dlt,
	input  logic [31:0]            wval,
	input  logic [2:0]             cur,      // bit0 A, bit1 B, bit2 pressed
	input  logic [5:0]             en,
	output mred_pkg::lane_res_t    res,
	output logic [31:0]            pos,
	output logic [31:0]            dlt
);
	import mred_pkg::*;

	logic [2:0]  prev_q;
	logic [4:0]  flags_q;
	logic [31:0] pos_q, dlt_q;
	logic [4:0]  f_nxt;
	logic        step, neg;
	logic [1:0]  cp, pp;
	logic        f0, f1, f2, f3, f4;
	logic [31:0] d;

	assign cp = cur[1:0];
	assign pp = prev_q[1:0];

	always_comb begin
		f_nxt = flags_q;
		step = 1'b0;
		neg = 1'b0;
		f0 = 1'b0; f1 = 1'b0; f2 = 1'b0; f3 = 1'b0; f4 = 1'b0;
		if (cp != pp) begin
			if (pp == 2'd0) begin
				if (cp == 2'd1) f_nxt[0] = 1'b1;
				else if (cp == 2'd2) f_nxt[1] = 1'b1;
			end
			if (cp == 2'd3) begin
				f_nxt[4] = 1'b1;
			end else if (cp == 2'd0) begin
				f0 = f_nxt[0]; f1 = f_nxt[1]; f2 = f_nxt[2]; f3 = f_nxt[3]; f4 = f_nxt[4];
				if (pp == 2'd2) f2 = 1'b1;
				else if (pp == 2'd1) f3 = 1'b1;
				if ((f0 && (f2 || f4)) || (f2 && (f0 || f4))) begin
					step = 1'b1;
				end else if ((f1 && (f3 || f4)) || (f3 && (f1 || f4))) begin
					step = 1'b1;
					neg = 1'b1;
				end
				f_nxt = '0;
			end
		end
	end

	assign d = neg ? 32'hFFFF_FFFF : 32'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			flags_q <= '0;
			pos_q <= '0;
			dlt_q <= '0;
		end else if (tick) begin
			prev_q <= cur;
			flags_q <= f_nxt;
			if (step) begin
				pos_q <= pos_q + d;
				dlt_q <= dlt_q + d;
			end
		end else begin
			if (set_pos) pos_q <= wval;
			if (set_dlt) dlt_q <= wval;
		end
	end

	always_comb begin
		res.step = step;
		res.stp_neg = neg;
		res.sw_plvl = cur[2] && en[2];
		res.sw_rlvl = !cur[2] && en[3];
		res.sw_press = (cur[2] != prev_q[2]) && cur[2] && en[4];
		res.sw_rel = (cur[2] != prev_q[2]) && !cur[2] && en[5];
		res.pos_new = pos_q + d;
	end

	assign pos = pos_q;
	assign dlt = dlt_q;
endmodule

// ===== rtl/mred_merge.sv =====
// Merge stage: queues lane records of one beat and drains them in lane order.
// Depends on mred_pkg.
module mred_merge #(
	parameter int NUM_ENCODERS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,           // capture a new record set
	input  mred_pkg::rec_t       recs [4*NUM_ENCODERS],
	input  logic [4*NUM_ENCODERS-1:0] vld,
	input  logic                 irq_in,
	output logic                 busy,
	output mred_pkg::rec_t       out_rec,
	output logic                 out_last,
	output logic                 out_irq,
	output logic                 out_valid,
	input  logic                 out_ready
);
	import mred_pkg::*;
	localparam int NR = 4 * NUM_ENCODERS;
	localparam int IW = $clog2(NR + 1);

	rec_t        rec_q [NR];
	logic [NR-1:0] pend_q;
	logic        irq_q;
	logic [IW-1:0] idx;
	logic        found;
	logic [NR-1:0] rest;

	// lowest pending slot
	always_comb begin
		idx = '0;
		found = 1'b0;
		for (int i = NR - 1; i >= 0; i--) begin
			if (pend_q[i]) begin
				idx = IW'(i);
				found = 1'b1;
			end
		end
		rest = pend_q;
		if (found) rest[idx[$clog2(NR > 1 ? NR : 2)-1:0]] = 1'b0;
	end

	assign out_valid = found;
	assign out_rec = rec_q[idx[$clog2(NR > 1 ? NR : 2)-1:0]];
	assign out_last = (rest == '0);
	assign out_irq = irq_q;
	assign busy = found;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			irq_q <= 1'b0;
		end else if (load) begin
			pend_q <= vld;
			irq_q <= irq_in;
		end else if (found && out_ready) begin
			pend_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < NR; i++) rec_q[i] <= recs[i];
		end
	end

	`include "multi_rotary_encoder_decoder_unit_assert.svh"
	`MRE_ASSERT_NXT(a_hold, clk, arst_n, found && !out_ready && !load, $stable(pend_q))
	`MRE_ASSERT_IMP(a_noload_busy, clk, arst_n, load, !found || (out_ready && out_last))
	`MRE_ASSERT_IMP(a_last_one, clk, arst_n, found && out_last, $onehot(pend_q))
endmodule

// ===== bench/tb_multi_rotary_encoder_decoder_unit.sv =====
// Testbench for the multi-lane rotary encoder decoder: directed table, then random beats.
// Depends on mred_pkg and multi_rotary_encoder_decoder_unit; checks records against a predictor.
module tb_multi_rotary_encoder_decoder_unit;
	import mred_pkg::*;

	localparam int NENC = 8;

	typedef struct packed {
		logic [2:0]  kind;
		logic [2:0]  enc;
		logic [31:0] value;
		logic [1:0]  edge_res;
		logic        last;
		logic        irq;
	} exp_rec_t;

	typedef struct {
		logic [2:0]  action;
		logic [7:0]  a;
		logic [7:0]  b;
		logic [7:0]  s;
		logic [3:0]  idx;
		logic [1:0]  sel;
		logic [31:0] wv;
		logic        has_exp;
		logic [2:0]  ekind;
		logic [31:0] evalue;
	} row_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic        cfg_index = 0;
	logic [47:0] cfg_wdata = '0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [71:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [47:0] m_tdata;
	logic        m_tlast;

	multi_rotary_encoder_decoder_unit #(.NUM_ENCODERS(NENC)) dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.s_tdata(s_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
		.m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	// predictor state
	logic [31:0] pos_q [NENC];
	logic [31:0] dlt_q [NENC];
	logic [2:0]  prev_q [NENC];
	logic [4:0]  flg_q [NENC];
	logic        rdy_q [NENC];
	logic [47:0] ev_en;
	logic [7:0]  irq_en;

	exp_rec_t pending_recs [$];
	int errors = 0;
	int send_idle = 29;
	int recv_idle = 58;
	int hold_cycles = 0;
	row_t dir_rows [$];

	function automatic exp_rec_t mk(logic [2:0] k, logic [2:0] e, logic [31:0] v,
			logic [1:0] ed);
		exp_rec_t r;
		r = '0;
		r.kind = k;
		r.enc = e;
		r.value = v;
		r.edge_res = ed;
		return r;
	endfunction

	task automatic decode_beat(input row_t it);
		exp_rec_t recs [$];
		logic [5:0] en;
		logic [2:0] cur, prv;
		logic [1:0] cp, pp;
		logic [4:0] f;
		logic [31:0] d;
		logic csw, psw, sw, anyirq;
		int step;
		case (it.action)
			ACT_TICK: begin
				for (int e = 0; e < NENC; e++) begin
					en = ev_en[6*e +: 6];
					cur = {~it.s[e], ~it.b[e], ~it.a[e]};
					prv = prev_q[e];
					cp = cur[1:0];
					pp = prv[1:0];
					f = flg_q[e];
					step = 0;
					sw = 0;
					if (cp != pp) begin
						if (pp == 0) begin
							if (cp == 1) f[0] = 1;
							else if (cp == 2) f[1] = 1;
						end
						if (cp == 3) f[4] = 1;
						else if (cp == 0) begin
							if (pp == 2) f[2] = 1;
							else if (pp == 1) f[3] = 1;
							if ((f[0] && (f[2] || f[4])) || (f[2] && (f[0] || f[4])))
								step = 1;
							else if ((f[1] && (f[3] || f[4])) || (f[3] && (f[1] || f[4])))
								step = -1;
							f = 0;
						end
					end
					flg_q[e] = f;
					if (step != 0) begin
						d = (step > 0) ? 32'd1 : 32'hFFFF_FFFF;
						pos_q[e] += d;
						dlt_q[e] += d;
						if (en[0]) recs.push_back(mk(KIND_VALUE, 3'(e), pos_q[e], EDGE_PLVL));
						if (en[1]) recs.push_back(mk(KIND_DELTA, 3'(e), d, EDGE_PLVL));
					end
					csw = cur[2];
					psw = prv[2];
					if (csw && en[2]) begin
						recs.push_back(mk(KIND_SWITCH, 3'(e), 0, EDGE_PLVL)); sw = 1;
					end
					if (!csw && en[3]) begin
						recs.push_back(mk(KIND_SWITCH, 3'(e), 0, EDGE_RLVL)); sw = 1;
					end
					if (csw != psw) begin
						if (csw && en[4]) begin
							recs.push_back(mk(KIND_SWITCH, 3'(e), 0, EDGE_PRESS)); sw = 1;
						end
						if (!csw && en[5]) begin
							recs.push_back(mk(KIND_SWITCH, 3'(e), 0, EDGE_REL)); sw = 1;
						end
					end
					if (step != 0 || sw) rdy_q[e] = 1;
					prev_q[e] = cur;
				end
			end
			ACT_SETPOS: if (it.idx < NENC) pos_q[it.idx] = it.wv;
			ACT_SETDLT: if (it.idx < NENC) dlt_q[it.idx] = it.wv;
			ACT_READ: begin
				if (it.idx >= NENC || it.sel == 2'd3)
					recs.push_back(mk(KIND_INVALID, it.idx[2:0], 0, 0));
				else if (it.sel == SEL_POS)
					recs.push_back(mk(KIND_POS, it.idx[2:0], pos_q[it.idx], 0));
				else if (it.sel == SEL_DLT)
					recs.push_back(mk(KIND_DREAD, it.idx[2:0], dlt_q[it.idx], 0));
				else
					recs.push_back(mk(KIND_STATUS, it.idx[2:0],
						{18'd0, ev_en[6*it.idx +: 6], 7'd0, rdy_q[it.idx]}, 0));
			end
			ACT_ACK: for (int e = 0; e < NENC; e++) rdy_q[e] = 0;
			default: ;
		endcase
		anyirq = 0;
		for (int e = 0; e < NENC; e++) if (rdy_q[e] && irq_en[e]) anyirq = 1;
		foreach (recs[k]) begin
			recs[k].irq = anyirq;
			recs[k].last = (k == recs.size() - 1);
			// typed-in expectation for table rows that carry one
			if (it.has_exp && (recs[k].kind != it.ekind || recs[k].value != it.evalue)) begin
				errors++;
				if (errors <= 10)
					$display("table row mismatch: exp kind %0d value %h, predictor %0d %h",
						it.ekind, it.evalue, recs[k].kind, recs[k].value);
			end
			pending_recs.push_back(recs[k]);
		end
	endtask

	// receive side
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				exp_rec_t got, want;
				got = {m_tdata[2:0], m_tdata[5:3], m_tdata[37:6], m_tdata[39:38],
					m_tlast, m_tdata[40]};
				if (pending_recs.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected record %h", got);
				end else begin
					want = pending_recs.pop_front();
					if (got !== want) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: exp kind %0d enc %0d val %h edge %0d last %0d irq %0d; got kind %0d enc %0d val %h edge %0d last %0d irq %0d",
								want.kind, want.enc, want.value, want.edge_res, want.last,
								want.irq, got.kind, got.enc, got.value, got.edge_res,
								got.last, got.irq);
					end
				end
			end
			if (hold_cycles > 0) begin
				hold_cycles <= hold_cycles - 1;
				m_tready <= 0;
			end else
				m_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	task automatic write_reg(input logic idx, input logic [47:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 0;
		if (idx == 1'b0) ev_en = val;
		else irq_en = val[7:0];
	endtask

	task automatic drain();
		while (pending_recs.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic send(input row_t it);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {7'd0, it.wv, it.sel, it.idx, it.s, it.b, it.a, it.action};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		decode_beat(it);
	endtask

	task automatic idle_in();
		s_tvalid <= 0;
		@(posedge clk);
	endtask

	function automatic row_t mk_row(logic [2:0] act, logic [7:0] a, logic [7:0] b,
			logic [7:0] s, logic [3:0] idx, logic [1:0] sel, logic [31:0] wv);
		row_t r;
		r.action = act; r.a = a; r.b = b; r.s = s; r.idx = idx; r.sel = sel; r.wv = wv;
		r.has_exp = 0; r.ekind = 0; r.evalue = 0;
		return r;
	endfunction

	function automatic row_t mk_chk(logic [3:0] idx, logic [1:0] sel, logic [2:0] k,
			logic [31:0] v);
		row_t r;
		r = mk_row(ACT_READ, 8'hFF, 8'hFF, 8'hFF, idx, sel, 0);
		r.has_exp = 1; r.ekind = k; r.evalue = v;
		return r;
	endfunction

	// a tick with one quadrature phase on every lane; dir picks forward or backward
	function automatic row_t phase_row(int ph, logic dir, logic [7:0] sw);
		logic [7:0] a, b;
		case (ph)
			0: begin a = '1; b = '1; end
			1: begin a = dir ? 8'h00 : '1; b = dir ? '1 : 8'h00; end
			2: begin a = 8'h00; b = 8'h00; end
			default: begin a = dir ? '1 : 8'h00; b = dir ? 8'h00 : '1; end
		endcase
		return mk_row(ACT_TICK, a, b, sw, 0, 0, $urandom);
	endfunction

	// full detent per lane with random direction, random bounce and switch
	task automatic random_detent();
		logic [7:0] dir, sw;
		logic [7:0] a, b;
		dir = $urandom;
		sw = $urandom;
		for (int ph = 1; ph <= 4; ph++) begin
			if ($urandom_range(9) == 0) ph = ph - 1 + $urandom_range(1);
			if (ph > 4) break;
			for (int e = 0; e < NENC; e++) begin
				case (ph)
					1: begin a[e] = ~dir[e]; b[e] = dir[e]; end
					2: begin a[e] = 0; b[e] = 0; end
					3: begin a[e] = dir[e]; b[e] = ~dir[e]; end
					default: begin a[e] = 1; b[e] = 1; end
				endcase
			end
			if ($urandom_range(15) == 0) a = $urandom;
			send(mk_row(ACT_TICK, a, b, ($urandom_range(3) == 0) ? $urandom : sw,
				$urandom, $urandom, $urandom));
		end
	endtask

	task automatic random_item();
		int pick;
		pick = $urandom_range(99);
		if (pick < 45) random_detent();
		else if (pick < 60)
			send(mk_row(ACT_TICK, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom));
		else if (pick < 68)
			send(mk_row(ACT_SETPOS, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom));
		else if (pick < 75)
			send(mk_row(ACT_SETDLT, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom));
		else if (pick < 93)
			send(mk_row(ACT_READ, $urandom, $urandom, $urandom, $urandom_range(9),
				$urandom, $urandom));
		else
			send(mk_row($urandom_range(4, 7), $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom));
	endtask

	initial begin
		for (int e = 0; e < NENC; e++) begin
			pos_q[e] = 0; dlt_q[e] = 0; prev_q[e] = 0; flg_q[e] = 0; rdy_q[e] = 0;
		end
		ev_en = 0;
		irq_en = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// reads after reset, invalid reads, extremes of set values, then a set to an invalid index and unknown actions
		dir_rows.push_back(mk_chk(0, SEL_POS, KIND_POS, 0));
		dir_rows.push_back(mk_chk(7, SEL_DLT, KIND_DREAD, 0));
		dir_rows.push_back(mk_chk(3, SEL_STAT, KIND_STATUS, 0));
		dir_rows.push_back(mk_chk(8, SEL_POS, KIND_INVALID, 0));
		dir_rows.push_back(mk_chk(15, SEL_DLT, KIND_INVALID, 0));
		dir_rows.push_back(mk_chk(2, 2'd3, KIND_INVALID, 0));
		dir_rows.push_back(mk_row(ACT_SETPOS, 0, 0, 0, 1, 0, 32'h7FFF_FFFF));
		dir_rows.push_back(mk_chk(1, SEL_POS, KIND_POS, 32'h7FFF_FFFF));
		dir_rows.push_back(mk_row(ACT_SETDLT, 0, 0, 0, 6, 0, 32'h8000_0000));
		dir_rows.push_back(mk_chk(6, SEL_DLT, KIND_DREAD, 32'h8000_0000));
		dir_rows.push_back(mk_row(ACT_SETPOS, 0, 0, 0, 9, 0, 32'h1234_5678));
		dir_rows.push_back(mk_row(ACT_SETPOS, 0, 0, 0, 2, 0, 32'hFFFF_FFFF));
		dir_rows.push_back(mk_row(3'd5, 0, 0, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(3'd7, 8'hFF, 8'hFF, 8'hFF, 15, 3, 32'hFFFF_FFFF));
		foreach (dir_rows[i]) send(dir_rows[i]);
		idle_in();
		drain();

		write_reg(1'b0, 48'hFFFF_FFFF_FFFF);
		write_reg(1'b1, 8'hFF);
		dir_rows.delete();
		// forward detent on all lanes, switch pressed, then backward with release
		for (int ph = 1; ph <= 4; ph++) dir_rows.push_back(phase_row(ph % 4, 1, 8'h00));
		for (int ph = 1; ph <= 4; ph++) dir_rows.push_back(phase_row(ph % 4, 0, 8'hFF));
		// bounce: first edge only, back to rest, no step
		dir_rows.push_back(phase_row(1, 1, 8'hFF));
		dir_rows.push_back(phase_row(0, 1, 8'hFF));
		// first edge plus middle, then rest directly: counts
		dir_rows.push_back(phase_row(1, 1, 8'hFF));
		dir_rows.push_back(phase_row(2, 1, 8'hFF));
		dir_rows.push_back(phase_row(0, 1, 8'hFF));
		dir_rows.push_back(mk_row(ACT_READ, 0, 0, 0, 4, SEL_STAT, 0));
		dir_rows.push_back(mk_row(ACT_ACK, 0, 0, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(ACT_READ, 0, 0, 0, 4, SEL_STAT, 0));
		dir_rows.push_back(mk_row(ACT_READ, 0, 0, 0, 2, SEL_POS, 0));
		foreach (dir_rows[i]) send(dir_rows[i]);
		idle_in();
		drain();

		for (int phase = 0; phase < 3; phase++) begin
			if (phase == 1) begin send_idle = 58; recv_idle = 29; end
			if (phase == 2) begin send_idle = 0; recv_idle = 0; end
			write_reg(1'b0, (phase == 2) ? 48'd0 : {$urandom, $urandom});
			write_reg(1'b1, $urandom);
			if (phase == 2) begin
				for (int i = 0; i < 20; i++) random_item();
				idle_in();
				drain();
				write_reg(1'b0, 48'hFFFF_FFFF_FFFF);
				write_reg(1'b1, 8'h01);
				// long receiver hold-off while the sender keeps offering
				hold_cycles = 300;
			end
			for (int i = 0; i < 28; i++) random_item();
			// sender pauses until everything has come back
			idle_in();
			drain();
			for (int i = 0; i < 28; i++) random_item();
			idle_in();
			drain();
		end

		if (errors == 0 && pending_recs.size() == 0)
			$display("tb_multi_rotary_encoder_decoder_unit: PASS");
		else
			$display("tb_multi_rotary_encoder_decoder_unit: FAIL");
		$finish;
	end

	initial begin
		#2000000;
		$display("tb_multi_rotary_encoder_decoder_unit: FAIL");
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/mred_pkg.sv
rtl/mred_lane.sv
rtl/mred_merge.sv
rtl/multi_rotary_encoder_decoder_unit.sv
bench/tb_multi_rotary_encoder_decoder_unit.sv
